// File: src/tcp_rx_pkg.sv
package tcp_rx_pkg;

  // Largest payload that is still forwarded byte by byte (exclusive bound).
  localparam int unsigned MAX_PACKET_BYTES = 4096;
  localparam logic [16:0] MAX_PAYLOAD_LIMIT = 17'(MAX_PACKET_BYTES);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [15:0] PROTO_TCP = 16'd6;

  // Result queue geometry.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned OUT_DATA_W = 144;

  typedef struct packed {
    logic        kind;
    logic        last_result;
    logic [7:0]  payload_byte;
    logic [31:0] source_addr;
    logic [15:0] source_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic        syn_flag;
    logic [15:0] payload_length;
    logic        ip_check_ok;
    logic        tcp_check_ok;
    logic        length_error;
  } result_t;

  // Up to two results per input beat: a payload byte and then a summary.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

  // 16-bit one's-complement add with a single end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] v);
    logic [16:0] sum;
    sum = {1'b0, s} + {1'b0, v};
    return sum[15:0] + {15'b0, sum[16]};
  endfunction

endpackage

// File: src/tcp_rx_parse.sv
module tcp_rx_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                end_of_packet,
  output tcp_rx_pkg::push_t   push
);

  localparam logic [15:0] OFS_TOTLEN_HI = 16'd2;
  localparam logic [15:0] OFS_TOTLEN_LO = 16'd3;
  localparam logic [15:0] OFS_IPCHK_HI  = 16'd10;
  localparam logic [15:0] OFS_IPCHK_LO  = 16'd11;
  localparam logic [15:0] OFS_SADDR_LO  = 16'd12;
  localparam logic [15:0] OFS_SADDR_HI  = 16'd15;
  localparam logic [15:0] OFS_PSEUDO_HI = 16'd19;
  localparam logic [15:0] TCP_PORT_END  = 16'd1;
  localparam logic [15:0] TCP_SEQ_LO    = 16'd4;
  localparam logic [15:0] TCP_SEQ_HI    = 16'd7;
  localparam logic [15:0] TCP_ACK_LO    = 16'd8;
  localparam logic [15:0] TCP_ACK_HI    = 16'd11;
  localparam logic [15:0] TCP_DOFS      = 16'd12;
  localparam logic [15:0] TCP_FLAGS     = 16'd13;
  localparam logic [15:0] TCP_CHK_HI    = 16'd16;
  localparam logic [15:0] TCP_CHK_LO    = 16'd17;

  logic [15:0] idx_r;
  logic [5:0]  ihl_r, thl_r;
  logic [15:0] tl_r, ip_sum_r, tcp_sum_r, rx_ip_r, rx_tcp_r, port_r;
  logic [31:0] saddr_r, seq_r, ack_r;
  logic        syn_r;

  logic [5:0]  ihl_e, thl_e;
  logic [15:0] tl_e, ip_sum_e, tsum_a, tcp_sum_e, rx_ip_e, rx_tcp_e, port_e;
  logic [31:0] saddr_e, seq_e, ack_e;
  logic        syn_e;
  logic [15:0] part, t, pl, sum1, sum2;
  logic        in_tcp, under, trunc, tcp_add, fwd;
  logic [6:0]  hsum;
  logic [16:0] span, count;
  tcp_rx_pkg::result_t pay_res, sum_res;

  always_comb begin
    part   = idx_r[0] ? {8'h00, data_byte} : {data_byte, 8'h00};
    ihl_e  = (idx_r == 16'd0) ? {data_byte[3:0], 2'b00} : ihl_r;
    tl_e   = (idx_r == OFS_TOTLEN_HI || idx_r == OFS_TOTLEN_LO) ?
             {tl_r[7:0], data_byte} : tl_r;
    rx_ip_e = (idx_r == OFS_IPCHK_HI || idx_r == OFS_IPCHK_LO) ?
              {rx_ip_r[7:0], data_byte} : rx_ip_r;
    saddr_e = (idx_r >= OFS_SADDR_LO && idx_r <= OFS_SADDR_HI) ?
              {saddr_r[23:0], data_byte} : saddr_r;
    ip_sum_e = (idx_r < {10'b0, ihl_e} && idx_r != OFS_IPCHK_HI && idx_r != OFS_IPCHK_LO) ?
               tcp_rx_pkg::oc_add(ip_sum_r, part) : ip_sum_r;
    // The addresses also form the pseudo header of the TCP sum.
    tsum_a = (idx_r >= OFS_SADDR_LO && idx_r <= OFS_PSEUDO_HI) ?
             tcp_rx_pkg::oc_add(tcp_sum_r, part) : tcp_sum_r;

    in_tcp   = idx_r >= {10'b0, ihl_e};
    t        = idx_r - {10'b0, ihl_e};
    port_e   = (in_tcp && t <= TCP_PORT_END) ? {port_r[7:0], data_byte} : port_r;
    seq_e    = (in_tcp && t >= TCP_SEQ_LO && t <= TCP_SEQ_HI) ? {seq_r[23:0], data_byte} : seq_r;
    ack_e    = (in_tcp && t >= TCP_ACK_LO && t <= TCP_ACK_HI) ? {ack_r[23:0], data_byte} : ack_r;
    thl_e    = (in_tcp && t == TCP_DOFS) ? {data_byte[7:4], 2'b00} : thl_r;
    syn_e    = (in_tcp && t == TCP_FLAGS) ? data_byte[1] : syn_r;
    rx_tcp_e = (in_tcp && (t == TCP_CHK_HI || t == TCP_CHK_LO)) ?
               {rx_tcp_r[7:0], data_byte} : rx_tcp_r;

    hsum  = {1'b0, ihl_e} + {1'b0, thl_e};
    under = tl_e < {9'b0, hsum};
    pl    = under ? 16'd0 : tl_e - {9'b0, hsum};
    span  = {11'b0, thl_e} + {1'b0, pl};

    tcp_add = in_tcp && t != TCP_CHK_HI && t != TCP_CHK_LO &&
              (t <= TCP_DOFS || {1'b0, t} < span);
    tcp_sum_e = tcp_add ? tcp_rx_pkg::oc_add(tsum_a, part) : tsum_a;

    fwd = in_tcp && t > TCP_DOFS && pl != 16'd0 && {1'b0, pl} < tcp_rx_pkg::MAX_PAYLOAD_LIMIT &&
          t >= {10'b0, thl_e} && {1'b0, t} < span;

    count = {1'b0, idx_r} + 17'd1;
    trunc = count < {1'b0, tl_e} || count <= ({11'b0, ihl_e} + 17'd12);
    sum1  = tcp_rx_pkg::oc_add(tcp_sum_e, tcp_rx_pkg::PROTO_TCP);
    sum2  = tcp_rx_pkg::oc_add(sum1, span[15:0]);

    pay_res              = '0;
    pay_res.kind         = tcp_rx_pkg::KIND_PAYLOAD;
    pay_res.payload_byte = data_byte;

    sum_res                = '0;
    sum_res.kind           = tcp_rx_pkg::KIND_SUMMARY;
    sum_res.last_result    = 1'b1;
    sum_res.source_addr    = saddr_e;
    sum_res.source_port    = port_e;
    sum_res.seq_number     = seq_e;
    sum_res.ack_number     = ack_e;
    sum_res.syn_flag       = syn_e;
    sum_res.payload_length = pl;
    sum_res.ip_check_ok    = rx_ip_e == ~ip_sum_e;
    sum_res.tcp_check_ok   = rx_tcp_e == ~sum2;
    sum_res.length_error   = under || trunc;

    push.push0 = accept && (fwd || end_of_packet);
    push.push1 = accept && fwd && end_of_packet;
    push.res0  = fwd ? pay_res : sum_res;
    push.res1  = sum_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && end_of_packet)) begin
      idx_r     <= '0;
      ihl_r     <= '0;
      thl_r     <= '0;
      tl_r      <= '0;
      ip_sum_r  <= '0;
      tcp_sum_r <= '0;
      rx_ip_r   <= '0;
      rx_tcp_r  <= '0;
      port_r    <= '0;
      saddr_r   <= '0;
      seq_r     <= '0;
      ack_r     <= '0;
      syn_r     <= 1'b0;
    end else if (accept) begin
      if (idx_r != 16'hFFFF) begin
        idx_r <= idx_r + 16'd1;
      end
      ihl_r     <= ihl_e;
      thl_r     <= thl_e;
      tl_r      <= tl_e;
      ip_sum_r  <= ip_sum_e;
      tcp_sum_r <= tcp_sum_e;
      rx_ip_r   <= rx_ip_e;
      rx_tcp_r  <= rx_tcp_e;
      port_r    <= port_e;
      saddr_r   <= saddr_e;
      seq_r     <= seq_e;
      ack_r     <= ack_e;
      syn_r     <= syn_e;
    end
  end

endmodule

// File: src/tcp_rx_outq.sv
module tcp_rx_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  tcp_rx_pkg::push_t   push,
  output logic                room,
  output logic                res_valid,
  input  logic                res_ready,
  output tcp_rx_pkg::result_t res
);

  tcp_rx_pkg::result_t q_r [tcp_rx_pkg::QUEUE_DEPTH];
  logic [tcp_rx_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [tcp_rx_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic [tcp_rx_pkg::QPTR_W-1:0] wr_step;
  logic                          pop;

  // Room is kept for the two results a single beat can produce.
  assign room      = count_r <= tcp_rx_pkg::QCNT_W'(tcp_rx_pkg::QUEUE_DEPTH - 2);
  assign res_valid = count_r != '0;
  assign res       = q_r[rd_ptr_r];
  assign pop       = res_valid && res_ready;
  assign wr_step   = tcp_rx_pkg::QPTR_W'({1'b0, push.push0} + {1'b0, push.push1});

  always_comb begin
    count_nxt = count_r + tcp_rx_pkg::QCNT_W'(wr_step) - tcp_rx_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + wr_step;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + tcp_rx_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      q_r[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      q_r[wr_ptr_r + tcp_rx_pkg::QPTR_W'(1)] <= push.res1;
    end
  end

endmodule

// File: src/tcp_ipv4_receive_parser.sv
// Channel  | Direction | Beat
// ---------+-----------+------------------------------------------------------
// in_      | slave     | tdata = packet byte, tlast = final byte of the packet
// out_     | master    | tdata = result record, tuser = kind, tlast = summary
//
// Each byte is parsed in the cycle it is accepted; its results are registered
// into a four-entry result queue, from which out_ presents them in order.
// One byte is taken per cycle while the queue has room; a byte that yields both a payload result and
// a summary needs two output beats, so sustained rate is one byte per cycle
// while the consumer drains at least as many beats as are produced.
// in_tready drops only when the result queue cannot hold two more results.
// Synchronous active-low reset clears the parser state and empties the queue.
module tcp_ipv4_receive_parser (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,  // [7:0] data_byte
  input  logic                                  in_tlast,  // end_of_packet
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [7:0] payload_byte, [39:8] source_addr, [55:40] source_port,
  // [87:56] seq_number, [119:88] ack_number, [120] syn_flag,
  // [136:121] payload_length, [137] ip_check_ok, [138] tcp_check_ok,
  // [139] length_error, [143:140] zero
  output logic [tcp_rx_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                  out_tuser, // kind
  output logic                                  out_tlast  // last_result
);

  tcp_rx_pkg::push_t   push;
  tcp_rx_pkg::result_t res;
  logic                accept;

  assign accept = in_tvalid && in_tready;

  tcp_rx_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_tdata),
    .end_of_packet (in_tlast),
    .push          (push)
  );

  tcp_rx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_tready),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {4'b0000, res.length_error, res.tcp_check_ok, res.ip_check_ok,
                      res.payload_length, res.syn_flag, res.ack_number, res.seq_number,
                      res.source_port, res.source_addr, res.payload_byte};
  assign out_tuser = res.kind;
  assign out_tlast = res.last_result;

endmodule
